// ===== design/tvcs_pkg.sv =====
// Shared types and constants for the two-wire voice command sender.
// No dependencies; compiled first.
`default_nettype none

package tvcs_pkg;

    // Frame sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SETUP = 3'd2,
        PH_HIGH  = 3'd3,
        PH_LOW   = 3'd4,
        PH_END   = 3'd5
    } t_phase;

    // Input word operation codes
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Command code ranges
    localparam logic [7:0] VOL_FIRST  = 8'hE0;
    localparam logic [7:0] VOL_LAST   = 8'hE7;
    localparam logic [3:0] FRAME_BITS = 4'd8;

    // Timing register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW       = 2'd3;

    // Timing register reset values
    localparam logic [CFG_W-1:0] RST_START_LOW = 16'd5000;
    localparam logic [CFG_W-1:0] RST_SETUP     = 16'd150;
    localparam logic [CFG_W-1:0] RST_HIGH      = 16'd300;
    localparam logic [CFG_W-1:0] RST_LOW       = 16'd150;

    typedef struct packed {
        logic [CFG_W-1:0] start_low_ticks;
        logic [CFG_W-1:0] setup_ticks;
        logic [CFG_W-1:0] high_ticks;
        logic [CFG_W-1:0] low_ticks;
    } t_cfg;

    typedef struct packed {
        logic       data_line;
        logic       clock_line;
        logic       sending;
        logic       rejected;
        logic [7:0] last_played;
        logic [2:0] volume_level;
    } t_result;

endpackage

`default_nettype wire

// ===== design/tvcs_cmd_if.sv =====
// Input channel: operation and command code with valid/ready.
// Depends on nothing but the handshake convention.
`default_nettype none

interface tvcs_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] command_code;

    modport source (output valid, output operation, output command_code, input ready);
    modport sink   (input valid, input operation, input command_code, output ready);
endinterface

`default_nettype wire

// ===== design/tvcs_res_if.sv =====
// Output channel: wire levels and status with valid/ready.
// Depends on nothing but the handshake convention.
`default_nettype none

interface tvcs_res_if;
    logic       valid;
    logic       ready;
    logic       data_line;
    logic       clock_line;
    logic       sending;
    logic       rejected;
    logic [7:0] last_played;
    logic [2:0] volume_level;

    modport source (output valid, output data_line, output clock_line, output sending,
                    output rejected, output last_played, output volume_level, input ready);
    modport sink   (input valid, input data_line, input clock_line, input sending,
                    input rejected, input last_played, input volume_level, output ready);
endinterface

`default_nettype wire

// ===== design/two_wire_voice_command_sender.sv =====
// Top level of the two-wire voice command sender: timing registers,
// sequencer core and result register. Depends on tvcs_pkg, tvcs_cmd_if, tvcs_res_if.
//
//   channel   dir  modport  payload
//   i_cmd     in   sink     operation, command_code
//   o_res     out  source   data_line, clock_line, sending, rejected,
//                           last_played, volume_level
//   i_cfg_*   in   -        write enable, index, 16-bit data
//
// Every input word yields one result word in the cycle after acceptance. One word
// per cycle is sustained while o_res.ready is high; the result register is the only
// stage. i_cmd.ready drops only while a result is held and o_res.ready is low.
// Synchronous active-low reset; timing registers return to their defaults.
`default_nettype none

module two_wire_voice_command_sender (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tvcs_cmd_if.sink                            i_cmd,
    tvcs_res_if.source                          o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [tvcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tvcs_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import tvcs_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_accept;

    tvcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Accept while the result register is free or draining
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    tvcs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_operation    (i_cmd.operation),
        .i_command_code (i_cmd.command_code),
        .i_cfg          (w_cfg),
        .o_result       (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.data_line    = r_out.data_line;
    assign o_res.clock_line   = r_out.clock_line;
    assign o_res.sending      = r_out.sending;
    assign o_res.rejected     = r_out.rejected;
    assign o_res.last_played  = r_out.last_played;
    assign o_res.volume_level = r_out.volume_level;

endmodule

`default_nettype wire

// ===== design/tvcs_cfg_regs.sv =====
// Timing registers written through the plain write port.
// Depends on tvcs_pkg.
`default_nettype none

module tvcs_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tvcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tvcs_pkg::CFG_W-1:0]     i_cfg_wdata,
    output tvcs_pkg::t_cfg                      o_cfg
);
    import tvcs_pkg::*;

    t_cfg r_cfg;

    // One register per index, reset to the default timing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks <= RST_START_LOW;
            r_cfg.setup_ticks     <= RST_SETUP;
            r_cfg.high_ticks      <= RST_HIGH;
            r_cfg.low_ticks       <= RST_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_LOW: r_cfg.start_low_ticks <= i_cfg_wdata;
                CFG_SETUP:     r_cfg.setup_ticks     <= i_cfg_wdata;
                CFG_HIGH:      r_cfg.high_ticks      <= i_cfg_wdata;
                CFG_LOW:       r_cfg.low_ticks       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/tvcs_core.sv =====
// Frame sequencer and command decode; updates state once per accepted word.
// Depends on tvcs_pkg.
`default_nettype none

module tvcs_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_command_code,
    input  wire tvcs_pkg::t_cfg i_cfg,
    output tvcs_pkg::t_result o_result
);
    import tvcs_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [3:0]  r_bits_left,  n_bits_left;
    logic [7:0]  r_shift_byte, n_shift_byte;
    logic [15:0] r_tick_count, n_tick_count;
    logic        r_data_level, n_data_level;
    logic        r_clock_level, n_clock_level;
    logic [7:0]  r_last_code,  n_last_code;
    logic [2:0]  r_volume,     n_volume;

    logic        w_busy;
    logic        w_cmd;
    logic        w_start;
    logic        w_volume;
    logic        w_reject;
    logic        w_tick;
    logic        w_advance;
    logic [3:0]  w_bits_dec;
    logic [7:0]  w_shift_next;

    // Word decode
    assign w_busy       = (r_phase != PH_IDLE);
    assign w_cmd        = i_accept && (i_operation == OP_CMD);
    assign w_tick       = i_accept && (i_operation == OP_TICK) && w_busy;
    assign w_reject     = w_cmd && w_busy;
    assign w_start      = w_cmd && !w_busy && (i_command_code < VOL_FIRST);
    assign w_volume     = w_cmd && !w_busy && (i_command_code >= VOL_FIRST)
                          && (i_command_code <= VOL_LAST);
    assign w_advance    = w_tick && (r_tick_count <= 16'd1);
    assign w_bits_dec   = r_bits_left - 4'd1;
    assign w_shift_next = {1'b0, r_shift_byte[7:1]};

    // Next phase and phase timer
    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        if (w_start) begin
            n_phase      = PH_START;
            n_tick_count = i_cfg.start_low_ticks;
        end else if (w_advance) begin
            case (r_phase)
                PH_START: begin
                    n_phase      = PH_SETUP;
                    n_tick_count = i_cfg.setup_ticks;
                end
                PH_SETUP: begin
                    n_phase      = PH_HIGH;
                    n_tick_count = i_cfg.high_ticks;
                end
                PH_HIGH: begin
                    n_phase      = PH_LOW;
                    n_tick_count = i_cfg.low_ticks;
                end
                PH_LOW: begin
                    n_phase      = (w_bits_dec != 4'd0) ? PH_SETUP : PH_END;
                    n_tick_count = i_cfg.setup_ticks;
                end
                default: begin
                    n_phase      = PH_IDLE;
                    n_tick_count = 16'd0;
                end
            endcase
        end else if (w_tick) begin
            n_tick_count = r_tick_count - 16'd1;
        end
    end

    // Wire levels, shifter and remembered codes
    always_comb begin
        n_bits_left   = r_bits_left;
        n_shift_byte  = r_shift_byte;
        n_data_level  = r_data_level;
        n_clock_level = r_clock_level;
        n_last_code   = r_last_code;
        n_volume      = r_volume;
        if (w_start) begin
            n_last_code   = i_command_code;
            n_shift_byte  = i_command_code;
            n_bits_left   = FRAME_BITS;
            n_clock_level = 1'b0;
        end else if (w_volume) begin
            n_volume = i_command_code[2:0];
        end else if (w_advance) begin
            case (r_phase)
                PH_START: n_data_level  = r_shift_byte[0];
                PH_SETUP: n_clock_level = 1'b1;
                PH_HIGH:  n_clock_level = 1'b0;
                PH_LOW: begin
                    n_shift_byte = w_shift_next;
                    n_bits_left  = w_bits_dec;
                    n_data_level = (w_bits_dec != 4'd0) ? w_shift_next[0] : 1'b1;
                end
                PH_END:   n_clock_level = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bits_left   <= 4'd0;
            r_shift_byte  <= 8'd0;
            r_tick_count  <= 16'd0;
            r_data_level  <= 1'b1;
            r_clock_level <= 1'b1;
            r_last_code   <= 8'd0;
            r_volume      <= 3'd0;
        end else begin
            r_phase       <= n_phase;
            r_bits_left   <= n_bits_left;
            r_shift_byte  <= n_shift_byte;
            r_tick_count  <= n_tick_count;
            r_data_level  <= n_data_level;
            r_clock_level <= n_clock_level;
            r_last_code   <= n_last_code;
            r_volume      <= n_volume;
        end
    end

    // Result word reflects the state after this word
    assign o_result.data_line    = n_data_level;
    assign o_result.clock_line   = n_clock_level;
    assign o_result.sending      = (n_phase != PH_IDLE);
    assign o_result.rejected     = w_reject;
    assign o_result.last_played  = n_last_code;
    assign o_result.volume_level = n_volume;

endmodule

`default_nettype wire
